// File: rtl/core/battery_percent_tracker_core_defines.svh
// Assertion macros for the battery percentage tracker.
`ifndef BATTERY_PERCENT_TRACKER_CORE_DEFINES_SVH
`define BATTERY_PERCENT_TRACKER_CORE_DEFINES_SVH
// Clocked implication check with reset disable.
`define BPT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define BPT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: rtl/core/bpt_pkg.sv
// Package: default table depth, command codes, register addresses and divider constants of the battery tracker.
package bpt_pkg;
    localparam int LEVEL_STEPS_DEF = 100;
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_PWRON = 2'd2;
    localparam logic [1:0] CMD_LOAD  = 2'd3;
    localparam logic [2:0] REG_HOLDOFF  = 3'd0;
    localparam logic [2:0] REG_LOADDN   = 3'd1;
    localparam logic [2:0] REG_CHARGEUP = 3'd2;
    localparam logic [2:0] REG_FULLHOLD = 3'd3;
    localparam logic [2:0] REG_RECHMV   = 3'd4;
    localparam logic [2:0] REG_RECHLVL  = 3'd5;
    localparam logic [15:0] VMAX = 16'hFFFF;
    localparam logic [11:0] VSCALE = 12'd4095;
endpackage

// File: rtl/core/bpt_ram.sv
// Generic single-port RAM with registered read.
module bpt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 100
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: rtl/core/bpt_div.sv
// Restoring divider: saturated ref*4095/adc, one quotient bit per cycle.
module bpt_div
    import bpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [11:0] i_adc,
    input  logic [11:0] i_ref,
    output logic        o_done,
    output logic [15:0] o_quot
);
    // dividend fits 24 bits; quotient up to 24 bits, saturate to 16
    logic [23:0] r_num, n_num;
    logic [12:0] r_rem, n_rem;
    logic [23:0] r_q, n_q;
    logic [11:0] r_den;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic        r_zero;
    logic [12:0] w_trial;
    logic [23:0] w_prod;

    assign w_prod  = 24'(i_ref) * 24'(VSCALE);
    assign w_trial = {r_rem[11:0], r_num[23]};

    always_comb begin
        n_num = r_num; n_rem = r_rem; n_q = r_q; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        if (i_start) begin
            n_num = w_prod; n_rem = '0; n_q = '0; n_cnt = 5'd24;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[22:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_q = {r_q[22:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q = {r_q[22:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_num <= n_num; r_rem <= n_rem; r_q <= n_q;
        if (i_start) begin
            r_den  <= i_adc;
            r_zero <= (i_adc == 12'd0);
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_zero || (r_q[23:16] != 8'd0)) ? VMAX : r_q[15:0];
endmodule

// File: rtl/core/battery_percent_tracker_core.sv
// Battery percentage tracker: command sequencer, threshold table and shared divider/comparator.
// Table writes, load-on ticks and hold-off ticks go straight to the result; a load start first reads the table.
// A measured tick runs the divider; with the charger present it then reads a table entry for the charge-up check.
// Power-on runs the divider, checks entry 0 for low lock, else reads and compares entries upward from entry 1.
// Throughput: one item at a time; ready again the cycle after the result beat is taken.
// Reset (synchronous, active low) clears level, flags, counters and voltage; the table is undefined.
module battery_percent_tracker_core
    import bpt_pkg::*;
#(
    parameter int LEVEL_STEPS = LEVEL_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: cmd[1:0], load_on[2], usb_in[3], adc_sample[15:4], ref_sample[27:16],
    // entry_index[34:28], entry_mv[50:35], zero fill [55:51]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: level[6:0], low_lock[7], full_res[8], recharge_start[9], recharge_seen[10],
    // voltage_mv[26:11], zero fill [31:27]
    output logic [31:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = $clog2(LEVEL_STEPS);
    localparam int LW = $clog2(LEVEL_STEPS + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIV    = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_PO0    = 4'd3;
    localparam logic [3:0] S_PO1    = 4'd4;
    localparam logic [3:0] S_SRCH   = 4'd5;
    localparam logic [3:0] S_LOAD   = 4'd6;
    localparam logic [3:0] S_TICK   = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;
    localparam logic [3:0] S_WAIT   = 4'd9;

    // config registers
    logic [4:0]  r_holdoff_ticks;
    logic [6:0]  r_load_down_ticks;
    logic [8:0]  r_charge_up_ticks;
    logic [12:0] r_full_hold_steps;
    logic [15:0] r_recharge_mv;
    logic [6:0]  r_recharge_level;

    // state
    logic [3:0]  r_st, n_st;
    logic [LW-1:0] r_level, n_level;
    logic r_low_lock, n_low_lock, r_full, n_full, r_seen, n_seen, r_pend, n_pend;
    logic r_pulse, n_pulse;
    logic [4:0]  r_hold, n_hold;
    logic [6:0]  r_ltc, n_ltc;
    logic [8:0]  r_ctc, n_ctc;
    logic [12:0] r_fhc, n_fhc;
    logic [15:0] r_volt, n_volt;
    logic [AW-1:0] r_idx, n_idx;
    logic [1:0]  r_cmd;
    logic        r_usb;
    logic        r_ovalid, n_ovalid;

    logic        w_acc, w_we, w_dstart, w_ddone;
    logic [AW-1:0] w_addr;
    logic [15:0] w_rdata, w_quot;
    logic [7:0]  w_lnext;
    logic [LW-1:0] w_rl;

    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_st == S_IDLE) && !r_ovalid;
    assign w_we = w_acc && (s_axis_tdata[1:0] == CMD_WRITE)
                  && (s_axis_tdata[34:28] < 7'(LEVEL_STEPS));
    assign w_addr = w_acc ? s_axis_tdata[28 +: AW] : r_idx;
    assign w_dstart = (r_st == S_IDLE) && w_acc && (s_axis_tdata[1:0] != CMD_WRITE)
                      && (s_axis_tdata[1:0] != CMD_LOAD);

    bpt_ram #(.WIDTH(16), .DEPTH(LEVEL_STEPS)) u_tab (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(s_axis_tdata[50:35]), .o_rdata(w_rdata)
    );

    bpt_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_adc(s_axis_tdata[15:4]), .i_ref(s_axis_tdata[27:16]),
        .o_done(w_ddone), .o_quot(w_quot)
    );

    assign w_lnext = {1'b0, r_ltc} + 8'd1;
    assign w_rl = (r_recharge_level > 7'(LEVEL_STEPS)) ? LW'(LEVEL_STEPS)
                                                      : LW'(r_recharge_level);

    // sequencer
    always_comb begin
        n_st = r_st; n_level = r_level; n_low_lock = r_low_lock; n_full = r_full;
        n_seen = r_seen; n_pend = r_pend; n_pulse = r_pulse; n_hold = r_hold;
        n_ltc = r_ltc; n_ctc = r_ctc; n_fhc = r_fhc; n_volt = r_volt; n_idx = r_idx;
        n_ovalid = r_ovalid;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_st)
            S_IDLE: begin
                if (w_acc) begin
                    n_pulse = 1'b0;
                    unique case (s_axis_tdata[1:0])
                        CMD_WRITE: n_st = S_OUT;
                        CMD_PWRON: n_st = S_DIV;
                        CMD_LOAD: begin
                            n_idx = (r_level > LW'(1)) ? AW'(r_level - LW'(1)) : '0;
                            n_st = S_RD;
                        end
                        default: begin
                            if (s_axis_tdata[2]) begin
                                n_hold = r_holdoff_ticks;
                                n_ctc = '0;
                                if (w_lnext > {1'b0, r_load_down_ticks}) begin
                                    n_ltc = '0; n_pend = 1'b1;
                                end else begin
                                    n_ltc = w_lnext[6:0];
                                end
                                n_st = S_OUT;
                            end else begin
                                n_level = r_level;
                                if (r_pend) begin
                                    n_pend = 1'b0;
                                    if (r_level != '0) n_level = r_level - LW'(1);
                                end
                                if (r_hold != '0) begin
                                    n_hold = r_hold - 5'd1;
                                    n_st = S_OUT;
                                end else begin
                                    n_st = S_DIV;
                                end
                            end
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (w_ddone) begin
                    n_volt = w_quot;
                    if (r_cmd == CMD_PWRON) begin
                        n_idx = '0;
                        n_st = S_PO0;
                    end else if (!r_usb) begin
                        n_st = S_OUT;
                    end else begin
                        n_idx = (r_level < LW'(LEVEL_STEPS)) ? AW'(r_level) : '0;
                        n_st = S_RD;
                    end
                end
            end
            S_RD: begin
                // wait here for the registered read
                n_st = (r_cmd == CMD_LOAD) ? S_LOAD
                     : (r_cmd == CMD_PWRON) ? S_SRCH : S_TICK;
            end
            S_PO0: n_st = S_PO1;
            S_PO1: begin
                // entry 0 result available
                n_low_lock = 1'b0;
                if (r_volt <= w_rdata) begin
                    n_level = '0; n_low_lock = 1'b1; n_st = S_OUT;
                end else begin
                    n_idx = AW'(1);
                    n_st = S_RD;
                end
            end
            S_SRCH: begin
                if (r_volt < w_rdata) begin
                    n_level = LW'(r_idx);
                    n_st = S_OUT;
                end else if (r_idx == AW'(LEVEL_STEPS - 1)) begin
                    // no entry above the voltage: full scale when strictly above top
                    if (r_volt > w_rdata) n_level = LW'(LEVEL_STEPS);
                    n_st = S_OUT;
                end else begin
                    n_idx = r_idx + AW'(1);
                    n_st = S_RD;
                end
            end
            S_LOAD: begin
                if (r_hold == '0) begin
                    if (r_level <= LW'(1)) begin
                        n_level = LW'(1);
                    end else if (r_volt < w_rdata) begin
                        n_ltc = '0; n_level = r_level - LW'(1); n_pend = 1'b0;
                    end
                end
                n_st = S_OUT;
            end
            S_TICK: begin
                n_level = r_level; n_full = r_full;
                if (r_level <= LW'(LEVEL_STEPS - 1)) begin
                    if (r_volt > w_rdata) begin
                        if (r_ctc < r_charge_up_ticks) begin
                            n_ctc = r_ctc + 9'd1;
                        end else begin
                            n_ctc = '0;
                            if (r_level == LW'(LEVEL_STEPS - 1)) begin
                                if (r_fhc < r_full_hold_steps) n_fhc = r_fhc + 13'd1;
                                else n_level = r_level + LW'(1);
                            end else begin
                                n_level = r_level + LW'(1);
                            end
                            n_low_lock = 1'b0; n_ltc = '0; n_pend = 1'b0;
                        end
                    end
                end else begin
                    n_ctc = '0; n_level = LW'(LEVEL_STEPS); n_full = 1'b1;
                    n_ltc = '0; n_pend = 1'b0;
                end
                if (n_level >= LW'(LEVEL_STEPS)) begin
                    n_level = LW'(LEVEL_STEPS); n_full = 1'b1;
                end
                if (n_full && (r_volt < r_recharge_mv)) begin
                    n_pulse = 1'b1; n_seen = 1'b1; n_level = w_rl; n_full = 1'b0;
                end
                n_st = S_OUT;
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_st = S_WAIT;
            end
            S_WAIT: begin
                if (!r_ovalid || m_axis_tready) n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_level <= '0; r_low_lock <= 1'b0; r_full <= 1'b0;
            r_seen <= 1'b0; r_pend <= 1'b0; r_pulse <= 1'b0; r_hold <= '0;
            r_ltc <= '0; r_ctc <= '0; r_fhc <= '0; r_volt <= '0; r_ovalid <= 1'b0;
            r_idx <= '0;
        end else begin
            r_st <= n_st; r_level <= n_level; r_low_lock <= n_low_lock; r_full <= n_full;
            r_seen <= n_seen; r_pend <= n_pend; r_pulse <= n_pulse; r_hold <= n_hold;
            r_ltc <= n_ltc; r_ctc <= n_ctc; r_fhc <= n_fhc; r_volt <= n_volt;
            r_ovalid <= n_ovalid; r_idx <= n_idx;
        end
        if (w_acc) begin
            r_cmd <= s_axis_tdata[1:0];
            r_usb <= s_axis_tdata[3];
        end
    end

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff_ticks <= 5'd25; r_load_down_ticks <= 7'd86;
            r_charge_up_ticks <= 9'd450; r_full_hold_steps <= 13'd6000;
            r_recharge_mv <= 16'd4050; r_recharge_level <= 7'd97;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_HOLDOFF:  r_holdoff_ticks <= pwdata[4:0];
                REG_LOADDN:   r_load_down_ticks <= pwdata[6:0];
                REG_CHARGEUP: r_charge_up_ticks <= pwdata[8:0];
                REG_FULLHOLD: r_full_hold_steps <= pwdata[12:0];
                REG_RECHMV:   r_recharge_mv <= pwdata[15:0];
                REG_RECHLVL:  r_recharge_level <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_HOLDOFF:  prdata = {27'd0, r_holdoff_ticks};
            REG_LOADDN:   prdata = {25'd0, r_load_down_ticks};
            REG_CHARGEUP: prdata = {23'd0, r_charge_up_ticks};
            REG_FULLHOLD: prdata = {19'd0, r_full_hold_steps};
            REG_RECHMV:   prdata = {16'd0, r_recharge_mv};
            REG_RECHLVL:  prdata = {25'd0, r_recharge_level};
            default:      prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // result beat
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {5'd0, r_volt, r_seen, r_pulse, r_full, r_low_lock,
                           7'(r_level)};
endmodule

// File: rtl/core/bpt_checker.sv
// Port-level checker for the battery tracker, bound to the top level.
`include "battery_percent_tracker_core_defines.svh"
module bpt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    `BPT_ASSERT(a_no_overlap, i_clk, i_rst_n, m_axis_tvalid |-> !s_axis_tready, "ready while result pending")
    `BPT_ASSERT(a_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata), "result changed under stall")
    `BPT_ASSERT(a_level_range, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tdata[6:0] <= 7'd100), "level out of range")
    `BPT_ASSERT(a_pulse_clears_full, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tdata[9]) |-> (!m_axis_tdata[8] && m_axis_tdata[10]), "recharge pulse with full set or seen clear")
endmodule

bind battery_percent_tracker_core bpt_checker u_bpt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
